// File: hw/rtl/bc_pkg.sv
// Shared types, constants and the microcode table of the binomial coefficient block.
package bc_pkg;

  localparam int N_W       = 6;
  localparam int COEF_W    = 59;
  localparam int STAT_W    = 2;
  localparam int ACC_W     = 64;
  localparam int DIV_BITS  = 4;
  localparam int DIV_CNT_W = $clog2(ACC_W / DIV_BITS);
  localparam int UPC_W     = 3;
  localparam int UCODE_LEN = 2 ** UPC_W;
  localparam int N_LIMIT_DEF = 63;

  typedef logic [N_W-1:0]    nval_t;
  typedef logic [COEF_W-1:0] coef_t;
  typedef logic [STAT_W-1:0] status_t;
  typedef logic [UPC_W-1:0]  upc_t;

  localparam status_t STATUS_OK      = 2'd0;
  localparam status_t STATUS_N_RANGE = 2'd1;
  localparam status_t STATUS_K_RANGE = 2'd2;

  // Datapath operation of one microstep
  typedef enum logic [2:0] {
    OP_NOP  = 3'd0,
    OP_LOAD = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_INC  = 3'd4,
    OP_EMIT = 3'd5
  } op_t;

  // Jump condition; when it holds the sequencer goes to target, else falls through
  typedef enum logic [2:0] {
    CND_NEVER    = 3'd0,
    CND_ALWAYS   = 3'd1,
    CND_NO_INPUT = 3'd2,
    CND_FINISHED = 3'd3,
    CND_DIV_MORE = 3'd4,
    CND_OUT_BUSY = 3'd5
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } ucode_t;

  // Status from the datapath back to the sequencer
  typedef struct packed {
    logic no_input;
    logic finished;
    logic div_more;
    logic out_busy;
  } flags_t;

  localparam upc_t UA_IDLE = 3'd0;
  localparam upc_t UA_TEST = 3'd1;
  localparam upc_t UA_MUL  = 3'd2;
  localparam upc_t UA_DIV  = 3'd3;
  localparam upc_t UA_INC  = 3'd4;
  localparam upc_t UA_EMIT = 3'd5;
  localparam upc_t UA_BACK = 3'd6;
  localparam upc_t UA_SPARE = 3'd7;

  function automatic ucode_t ucode_rom(input upc_t addr);
    ucode_t cw;
    unique case (addr)
      UA_IDLE:  cw = '{op: OP_LOAD, cond: CND_NO_INPUT, target: UA_IDLE};
      UA_TEST:  cw = '{op: OP_NOP,  cond: CND_FINISHED, target: UA_EMIT};
      UA_MUL:   cw = '{op: OP_MUL,  cond: CND_NEVER,    target: UA_IDLE};
      UA_DIV:   cw = '{op: OP_DIV,  cond: CND_DIV_MORE, target: UA_DIV};
      UA_INC:   cw = '{op: OP_INC,  cond: CND_ALWAYS,   target: UA_TEST};
      UA_EMIT:  cw = '{op: OP_EMIT, cond: CND_OUT_BUSY, target: UA_EMIT};
      UA_BACK:  cw = '{op: OP_NOP,  cond: CND_ALWAYS,   target: UA_IDLE};
      UA_SPARE: cw = '{op: OP_NOP,  cond: CND_ALWAYS,   target: UA_IDLE};
      default:  cw = '{op: OP_NOP,  cond: CND_ALWAYS,   target: UA_IDLE};
    endcase
    return cw;
  endfunction

endpackage

// File: hw/rtl/bc_in_if.sv
// Input channel: n and k with valid/ready handshake.
interface bc_in_if;
  import bc_pkg::*;
  logic  valid;
  logic  ready;
  nval_t n_value;
  nval_t k_value;

  modport source (output valid, output n_value, output k_value, input ready);
  modport sink   (input valid, input n_value, input k_value, output ready);
endinterface

// File: hw/rtl/bc_out_if.sv
// Result channel: coefficient and status with valid/ready handshake.
interface bc_out_if;
  import bc_pkg::*;
  logic    valid;
  logic    ready;
  coef_t   coefficient;
  status_t status;

  modport source (output valid, output coefficient, output status, input ready);
  modport sink   (input valid, input coefficient, input status, output ready);
endinterface

// File: hw/rtl/bc_sequencer.sv
// Microprogram counter, control store lookup and branch logic.
module bc_sequencer (
  input  logic            clk,
  input  logic            rst_n,
  input  bc_pkg::flags_t  flags,
  output bc_pkg::ucode_t  cw
);
  import bc_pkg::*;

  upc_t upc_r;
  upc_t upc_nxt;
  logic take;

  assign cw = ucode_rom(upc_r);

  always_comb begin
    unique case (cw.cond)
      CND_NEVER:    take = 1'b0;
      CND_ALWAYS:   take = 1'b1;
      CND_NO_INPUT: take = flags.no_input;
      CND_FINISHED: take = flags.finished;
      CND_DIV_MORE: take = flags.div_more;
      CND_OUT_BUSY: take = flags.out_busy;
      default:      take = 1'b1;
    endcase
    upc_nxt = take ? cw.target : upc_t'(upc_r + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UA_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// File: hw/rtl/bc_datapath.sv
// Accumulator, 6-bit multiplier, radix-16 exact divider and output register.
module bc_datapath #(
  parameter int N_LIMIT = bc_pkg::N_LIMIT_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  bc_pkg::ucode_t cw,
  output bc_pkg::flags_t flags,
  bc_in_if.sink          in_chan,
  bc_out_if.source       out_chan
);
  import bc_pkg::*;

  logic [ACC_W-1:0]     acc_r;
  logic [N_W-1:0]       rem_r;
  nval_t                n_r, k_r, i_r;
  status_t              status_r;
  logic                 zero_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 out_valid_r;
  coef_t                coef_r;
  status_t              out_status_r;

  logic             load, emit;
  logic             n_bad, k_bad, k_edge;
  nval_t            fac;
  logic [ACC_W-1:0] prod;
  logic [ACC_W-1:0] acc_d;
  logic [N_W-1:0]   rem_d;
  logic [N_W:0]     trial, diff;

  assign load = (cw.op == OP_LOAD) && in_chan.valid;
  assign emit = (cw.op == OP_EMIT) && !flags.out_busy;

  assign n_bad  = {1'b0, in_chan.n_value} >= (N_W+1)'(N_LIMIT);
  assign k_bad  = {1'b0, in_chan.k_value} > ({1'b0, in_chan.n_value} + 1'b1);
  assign k_edge = {1'b0, in_chan.k_value} == ({1'b0, in_chan.n_value} + 1'b1);

  // factor n+1-i, always >= 1 inside the loop since i <= k <= n
  assign fac  = N_W'(({1'b0, n_r} + 1'b1) - {1'b0, i_r});
  assign prod = acc_r * ACC_W'(fac);

  // Four restoring division steps per cycle; quotient shifts into the accumulator
  always_comb begin
    acc_d = acc_r;
    rem_d = rem_r;
    trial = '0;
    diff  = '0;
    for (int s = 0; s < DIV_BITS; s++) begin
      trial = {rem_d, acc_d[ACC_W-1]};
      diff  = trial - {1'b0, i_r};
      acc_d = {acc_d[ACC_W-2:0], 1'b0};
      if (trial >= {1'b0, i_r}) begin
        rem_d    = diff[N_W-1:0];
        acc_d[0] = 1'b1;
      end else begin
        rem_d = trial[N_W-1:0];
      end
    end
  end

  assign flags.no_input = !in_chan.valid;
  assign flags.finished = zero_r || (i_r > k_r);
  assign flags.div_more = cnt_r != '1;
  assign flags.out_busy = out_valid_r && !out_chan.ready;

  assign in_chan.ready        = (cw.op == OP_LOAD);
  assign out_chan.valid       = out_valid_r;
  assign out_chan.coefficient = coef_r;
  assign out_chan.status      = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cw.op)
      OP_LOAD: begin
        if (load) begin
          n_r    <= in_chan.n_value;
          k_r    <= in_chan.k_value;
          i_r    <= nval_t'(1);
          acc_r  <= ACC_W'(1);
          zero_r <= n_bad || k_bad || k_edge;
          if (n_bad) begin
            status_r <= STATUS_N_RANGE;
          end else if (k_bad) begin
            status_r <= STATUS_K_RANGE;
          end else begin
            status_r <= STATUS_OK;
          end
        end
      end
      OP_MUL: begin
        acc_r <= prod;
        rem_r <= '0;
        cnt_r <= '0;
      end
      OP_DIV: begin
        acc_r <= acc_d;
        rem_r <= rem_d;
        cnt_r <= cnt_r + 1'b1;
      end
      OP_INC: begin
        i_r <= i_r + 1'b1;
      end
      OP_EMIT: begin
        if (emit) begin
          coef_r       <= zero_r ? '0 : acc_r[COEF_W-1:0];
          out_status_r <= status_r;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hw/rtl/binomial_coefficient.sv
// Binomial coefficient C(n,k) unit, top level.
// Usage:
//   in_chan  (sink):   n_value, k_value; a transaction when valid and ready are high.
//   out_chan (source): coefficient, status; held in an output register until taken.
//   One item is worked at a time. in_chan.ready is high only while the
//   microsequencer sits in its idle step.
//   A valid request runs k loop iterations before out_chan.valid rises; n out of
//   range, k out of range and k equal to n+1 skip the loop. The worst case is
//   k = 62. The next item is taken only after the previous one has been emitted.
//   Each iteration costs one test, one multiply by (n+1-i), sixteen steps of
//   the radix-16 exact divide by i, and one increment; the divide sets the rate.
//   status: 0 ok, 1 n at or above N_LIMIT, 2 k above n+1; coefficient is 0
//   on either error and when k equals n+1.
//   Reset (rst_n low, synchronous) returns the sequencer to idle and drops
//   out_chan.valid.
//   If the receiver stalls, the result stays in the output register and the
//   next item may be accepted and worked; its result waits in the emit step
//   until the register is free.
module binomial_coefficient #(
  parameter int N_LIMIT = bc_pkg::N_LIMIT_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  bc_in_if.sink    in_chan,
  bc_out_if.source out_chan
);
  import bc_pkg::*;

  ucode_t cw;
  flags_t flags;

  bc_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .cw    (cw)
  );

  bc_datapath #(
    .N_LIMIT (N_LIMIT)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cw       (cw),
    .flags    (flags),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

endmodule
